### rtl/spbd_pkg.sv
// ----------------------------------------------------------------------------
// spbd_pkg
// Shared types and constants for the sequence-points blob decoder.
// ----------------------------------------------------------------------------
package spbd_pkg;

  // record kinds on the result channel
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_DOC    = 3'd1;
  localparam logic [2:0] KIND_HIDDEN = 3'd2;
  localparam logic [2:0] KIND_POINT  = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // marker lines for document-change and hidden records
  localparam logic [31:0] LINE_DOC_CHANGE = 32'h00FD_DFDD;
  localparam logic [31:0] LINE_HIDDEN     = 32'h00FE_EFEE;

  // field being parsed
  typedef enum logic [6:0] {
    PH_SIG    = 7'b000_0001,
    PH_DOC    = 7'b000_0010,
    PH_IL     = 7'b000_0100,
    PH_SECOND = 7'b000_1000,
    PH_COLS   = 7'b001_0000,
    PH_SLINE  = 7'b010_0000,
    PH_SCOL   = 7'b100_0000
  } phase_t;

  // width class of a compressed integer
  typedef enum logic [1:0] {
    W7  = 2'd0,
    W14 = 2'd1,
    W29 = 2'd2
  } int_width_t;

  // compressed integer assembler result
  typedef struct packed {
    logic        done;
    logic        invalid;
    logic [28:0] value;
    logic [1:0]  bytes_left;
    int_width_t  width;
    logic [31:0] sval;
  } int_res_t;

endpackage

### rtl/spbd_in_if.sv
// ----------------------------------------------------------------------------
// spbd_in_if
// Byte channel into the decoder: valid/ready plus one blob byte and flags.
// ----------------------------------------------------------------------------
interface spbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       blob_start;
  logic       blob_end;
  logic       single_document;

  modport source (output valid, data_byte, blob_start, blob_end, single_document,
                  input ready);
  modport sink (input valid, data_byte, blob_start, blob_end, single_document,
                output ready);
endinterface

### rtl/spbd_out_if.sv
// ----------------------------------------------------------------------------
// spbd_out_if
// Record channel out of the decoder: valid/ready plus one decoded record.
// ----------------------------------------------------------------------------
interface spbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [28:0] value_field;
  logic [31:0] first_line;
  logic [31:0] final_line;
  logic [31:0] first_column;
  logic [31:0] final_column;

  modport source (output valid, record_kind, value_field, first_line, final_line,
                  first_column, final_column, input ready);
  modport sink (input valid, record_kind, value_field, first_line, final_line,
                first_column, final_column, output ready);
endinterface

### rtl/spbd_int_asm.sv
// ----------------------------------------------------------------------------
// spbd_int_asm
// Compressed integer assembler: folds one byte into the running integer and
// gives the raw and sign-rotated value when the integer completes.
// ----------------------------------------------------------------------------
module spbd_int_asm
  import spbd_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  logic [1:0]  bytes_left,
  input  logic [28:0] acc,
  input  int_width_t  width,
  output int_res_t    res
);

  logic [31:0] mag;

  always_comb begin
    res = '0;
    res.width = width;
    if (bytes_left == 2'd0) begin
      if (!data_byte[7]) begin
        res.value = {22'd0, data_byte[6:0]};
        res.width = W7;
        res.done  = 1'b1;
      end else if (data_byte[7:6] == 2'b10) begin
        res.value      = {23'd0, data_byte[5:0]};
        res.width      = W14;
        res.bytes_left = 2'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        res.value      = {24'd0, data_byte[4:0]};
        res.width      = W29;
        res.bytes_left = 2'd3;
      end else begin
        res.invalid = 1'b1;
      end
    end else begin
      res.value      = {acc[20:0], data_byte};
      res.bytes_left = bytes_left - 2'd1;
      res.done       = (bytes_left == 2'd1);
    end

    // rotated signed form: bit 0 is the sign, the rest sign-extends
    mag = {4'd0, res.value[28:1]};
    if (res.value[0]) begin
      unique case (res.width)
        W7:      mag[31:6]  = '1;
        W14:     mag[31:13] = '1;
        W29:     mag[31:28] = '1;
        default: mag[31:28] = '1;
      endcase
    end
    res.sval = mag;
  end

endmodule

### rtl/sequence_point_blob_decoder_top.sv
// ----------------------------------------------------------------------------
// sequence_point_blob_decoder_top
// Sequence-points blob decoder: one byte per request, at most one record out.
// ----------------------------------------------------------------------------
// output: the record is registered and appears in the cycle after the byte that
//   completes it is taken
// throughput: one byte per cycle, limited only by the output register being
//   drained; the record path holds one 32-bit add after integer assembly
// reset: rst (synchronous) empties the output and returns the parser to the
//   header signature; blob_start on a byte returns the parser there before using it
module sequence_point_blob_decoder_top
  import spbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spbd_in_if.sink     blob,
  spbd_out_if.source  records
);

  // parser state
  phase_t      phase;
  logic [1:0]  bytes_left;
  logic [28:0] int_acc;
  int_width_t  int_width;
  logic [28:0] pending_offset_delta;
  logic [28:0] pending_line_span;
  logic [31:0] pending_col_end;     // column base plus column span
  logic [31:0] pending_start_line;
  logic [31:0] base_line;
  logic [31:0] base_column;
  logic        have_base;
  logic        first_record_flag;
  logic        halted;

  phase_t      phase_next;
  logic [1:0]  bytes_left_next;
  logic [28:0] int_acc_next;
  int_width_t  int_width_next;
  logic [28:0] pending_offset_delta_next;
  logic [28:0] pending_line_span_next;
  logic [31:0] pending_col_end_next;
  logic [31:0] pending_start_line_next;
  logic [31:0] base_line_next;
  logic [31:0] base_column_next;
  logic        have_base_next;
  logic        first_record_flag_next;
  logic        halted_next;

  // state as seen by this byte: blob_start wipes the control part
  phase_t      cur_phase;
  logic [1:0]  cur_bytes_left;
  logic        cur_have_base;
  logic        cur_first;
  logic        cur_halted;

  // output register
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [28:0] res_value;
  logic [31:0] res_first_line;
  logic [31:0] res_final_line;
  logic [31:0] res_first_column;
  logic [31:0] res_final_column;

  // result of this byte
  logic        emit;
  logic [2:0]  emit_kind;
  logic [28:0] emit_value;
  logic [31:0] emit_first_line;
  logic [31:0] emit_final_line;
  logic [31:0] emit_first_column;
  logic [31:0] emit_final_column;

  logic        accept;
  int_res_t    ir;
  logic [31:0] col_span;
  logic [31:0] delta;
  logic [31:0] col_base;

  // a byte is taken whenever the output register is free or being drained
  assign blob.ready = !res_valid || records.ready;
  assign accept     = blob.valid && blob.ready;

  assign cur_phase      = blob.blob_start ? PH_SIG : phase;
  assign cur_bytes_left = blob.blob_start ? 2'd0   : bytes_left;
  assign cur_have_base  = blob.blob_start ? 1'b0   : have_base;
  assign cur_first      = blob.blob_start ? 1'b1   : first_record_flag;
  assign cur_halted     = blob.blob_start ? 1'b0   : halted;

  spbd_int_asm u_int_asm (
    .data_byte  (blob.data_byte),
    .bytes_left (cur_bytes_left),
    .acc        (int_acc),
    .width      (int_width),
    .res        (ir)
  );

  // start fields are absolute until the first regular record
  assign delta    = cur_have_base ? ir.sval : {3'd0, ir.value};
  assign col_base = cur_have_base ? base_column : 32'd0;

  always_comb begin
    phase_next                = cur_phase;
    bytes_left_next           = cur_bytes_left;
    int_acc_next              = int_acc;
    int_width_next            = int_width;
    pending_offset_delta_next = pending_offset_delta;
    pending_line_span_next    = pending_line_span;
    pending_col_end_next      = pending_col_end;
    pending_start_line_next   = pending_start_line;
    base_line_next            = base_line;
    base_column_next          = base_column;
    have_base_next            = cur_have_base;
    first_record_flag_next    = cur_first;
    halted_next               = cur_halted;
    emit                      = 1'b0;
    emit_kind                 = KIND_ERROR;
    emit_value                = '0;
    emit_first_line           = '0;
    emit_final_line           = '0;
    emit_first_column         = '0;
    emit_final_column         = '0;
    col_span                  = ir.sval;

    if (!cur_halted) begin
      if (ir.invalid) begin
        // bad integer prefix
        emit        = 1'b1;
        halted_next = 1'b1;
      end else begin
        bytes_left_next = ir.bytes_left;
        int_acc_next    = ir.value;
        int_width_next  = ir.width;

        if (ir.done) begin
          unique case (cur_phase)
            PH_SIG: begin
              emit       = 1'b1;
              emit_kind  = KIND_HEADER;
              emit_value = ir.value;
              phase_next = blob.single_document ? PH_IL : PH_DOC;
            end
            PH_DOC: begin
              emit            = 1'b1;
              emit_kind       = KIND_DOC;
              emit_value      = ir.value;
              emit_first_line = LINE_DOC_CHANGE;
              emit_final_line = LINE_DOC_CHANGE;
              phase_next      = PH_IL;
            end
            PH_IL: begin
              pending_offset_delta_next = ir.value;
              phase_next                = PH_SECOND;
            end
            PH_SECOND: begin
              // zero offset delta after the first record marks a document change
              if (pending_offset_delta == 29'd0 && !cur_first) begin
                emit            = 1'b1;
                emit_kind       = KIND_DOC;
                emit_value      = ir.value;
                emit_first_line = LINE_DOC_CHANGE;
                emit_final_line = LINE_DOC_CHANGE;
                phase_next      = PH_IL;
              end else begin
                pending_line_span_next = ir.value;
                phase_next             = PH_COLS;
              end
            end
            PH_COLS: begin
              if (pending_line_span == 29'd0) begin
                col_span = {3'd0, ir.value};
              end
              if (pending_line_span == 29'd0 && ir.value == 29'd0) begin
                // hidden record: no span at all
                emit                   = 1'b1;
                emit_kind              = KIND_HIDDEN;
                emit_value             = pending_offset_delta;
                emit_first_line        = LINE_HIDDEN;
                emit_final_line        = LINE_HIDDEN;
                first_record_flag_next = 1'b0;
                phase_next             = PH_IL;
              end else begin
                // fold the column base in now so the end column needs one add
                pending_col_end_next = col_base + col_span;
                phase_next           = PH_SLINE;
              end
            end
            PH_SLINE: begin
              pending_start_line_next = (cur_have_base ? base_line : 32'd0) + delta;
              phase_next              = PH_SCOL;
            end
            PH_SCOL: begin
              emit                   = 1'b1;
              emit_kind              = KIND_POINT;
              emit_value             = pending_offset_delta;
              emit_first_line        = pending_start_line;
              emit_final_line        = pending_start_line + {3'd0, pending_line_span};
              emit_first_column      = col_base + delta;
              emit_final_column      = pending_col_end + delta;
              base_line_next         = pending_start_line;
              base_column_next       = col_base + delta;
              have_base_next         = 1'b1;
              first_record_flag_next = 1'b0;
              phase_next             = PH_IL;
            end
            default: begin
              emit        = 1'b1;
              emit_kind   = KIND_ERROR;
              halted_next = 1'b1;
            end
          endcase
        end

        // blob end: clean only at a record boundary after some record
        if (!halted_next && blob.blob_end) begin
          halted_next = 1'b1;
          if (!(phase_next == PH_IL && ir.bytes_left == 2'd0 && !first_record_flag_next))
          begin
            emit              = 1'b1;
            emit_kind         = KIND_ERROR;
            emit_value        = '0;
            emit_first_line   = '0;
            emit_final_line   = '0;
            emit_first_column = '0;
            emit_final_column = '0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SIG;
      bytes_left        <= 2'd0;
      have_base         <= 1'b0;
      first_record_flag <= 1'b1;
      halted            <= 1'b0;
      int_width         <= W7;
    end else if (accept) begin
      phase             <= phase_next;
      bytes_left        <= bytes_left_next;
      have_base         <= have_base_next;
      first_record_flag <= first_record_flag_next;
      halted            <= halted_next;
      int_width         <= int_width_next;
    end
  end

  // payload state, only read after it has been written for this blob
  always_ff @(posedge clk) begin
    if (accept) begin
      int_acc              <= int_acc_next;
      pending_offset_delta <= pending_offset_delta_next;
      pending_line_span    <= pending_line_span_next;
      pending_col_end      <= pending_col_end_next;
      pending_start_line   <= pending_start_line_next;
      base_line            <= base_line_next;
      base_column          <= base_column_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (records.valid && records.ready) begin
        res_valid <= 1'b0;
      end
      if (accept && emit) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind         <= emit_kind;
      res_value        <= emit_value;
      res_first_line   <= emit_first_line;
      res_final_line   <= emit_final_line;
      res_first_column <= emit_first_column;
      res_final_column <= emit_final_column;
    end
  end

  assign records.valid        = res_valid;
  assign records.record_kind  = res_kind;
  assign records.value_field  = res_value;
  assign records.first_line   = res_first_line;
  assign records.final_line   = res_final_line;
  assign records.first_column = res_first_column;
  assign records.final_column = res_final_column;

  // a stalled record blocks new bytes
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    records.valid && !records.ready |-> !blob.ready)
    else $error("byte taken while a record is stalled");

  // invalid prefix on a fresh blob gives an error record
  a_bad_prefix: assert property (@(posedge clk) disable iff (rst)
    accept && blob.blob_start && blob.data_byte[7:5] == 3'b111
    |=> records.valid && records.record_kind == KIND_ERROR)
    else $error("invalid prefix gave no error record");

  // an error record always halts the parser
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    accept && emit && emit_kind == KIND_ERROR |=> halted)
    else $error("error record without halt");

  // a regular record sets the delta base
  a_point_sets_base: assert property (@(posedge clk) disable iff (rst)
    accept && emit && emit_kind == KIND_POINT |=> have_base && !first_record_flag)
    else $error("sequence point did not set the base");

endmodule

### test/spbd_checker.sv
// ----------------------------------------------------------------------------
// spbd_checker
// Watches both decoder channels, keeps its own copy of the parser state to
// predict each record, and compares every record the decoder hands out.
// ----------------------------------------------------------------------------
module spbd_checker
  import spbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spbd_in_if   blob,
  spbd_out_if  records,
  output int   fail_count,
  output int   pending,
  output int   records_seen,
  output int   points_seen,
  output int   errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [28:0] value;
    logic [31:0] line_a;
    logic [31:0] line_b;
    logic [31:0] col_a;
    logic [31:0] col_b;
  } record_t;

  record_t     want_q[$];

  // parser copy
  phase_t      seg_phase;
  logic [28:0] accum;
  logic [1:0]  more_bytes;
  int_width_t  acc_width;
  logic [28:0] off_delta;
  logic [28:0] span_lines;
  logic [31:0] span_cols;
  logic [31:0] line_start;
  logic [31:0] prev_line;
  logic [31:0] prev_col;
  logic        anchored;
  logic        no_record_yet;
  logic        stopped;

  initial begin
    fail_count   = 0;
    records_seen = 0;
    points_seen  = 0;
    errors_seen  = 0;
  end

  task automatic clear_state();
    seg_phase     = PH_SIG;
    accum         = '0;
    more_bytes    = '0;
    acc_width     = W7;
    off_delta     = '0;
    span_lines    = '0;
    span_cols     = '0;
    line_start    = '0;
    prev_line     = '0;
    prev_col      = '0;
    anchored      = 1'b0;
    no_record_yet = 1'b1;
    stopped       = 1'b0;
  endtask

  // bit 0 is the sign, the rest sign-extended from the integer's width
  function automatic logic [31:0] rotated(logic [28:0] raw, int_width_t w);
    logic [31:0] mag;
    int          n;
    n   = (w == W7) ? 7 : (w == W14) ? 14 : 29;
    mag = {3'b000, raw} >> 1;
    if (raw[0]) mag = mag | (32'hFFFF_FFFF << (n - 1));
    return mag;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start, input logic fin,
                             input logic single);
    logic        done;
    logic        got;
    logic [31:0] sv;
    logic [31:0] col;
    record_t     r;
    done = 1'b0;
    got  = 1'b0;
    r    = '0;
    if (start) clear_state();
    if (stopped) return;
    if (more_bytes == 2'd0) begin
      if (!b[7]) begin
        accum     = {21'b0, b};
        acc_width = W7;
        done      = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        accum      = {23'b0, b[5:0]};
        acc_width  = W14;
        more_bytes = 2'd1;
      end else if (b[7:5] == 3'b110) begin
        accum      = {24'b0, b[4:0]};
        acc_width  = W29;
        more_bytes = 2'd3;
      end else begin
        // invalid prefix
        r.kind  = KIND_ERROR;
        stopped = 1'b1;
        want_q.insert(want_q.size(), r);
        return;
      end
    end else begin
      accum      = {accum[20:0], b};
      more_bytes = more_bytes - 2'd1;
      done       = (more_bytes == 2'd0);
    end

    if (done) begin
      sv = rotated(accum, acc_width);
      case (seg_phase)
        PH_SIG: begin
          r.kind    = KIND_HEADER;
          r.value   = accum;
          got       = 1'b1;
          seg_phase = single ? PH_IL : PH_DOC;
        end
        PH_DOC: begin
          r         = '{KIND_DOC, accum, LINE_DOC_CHANGE, LINE_DOC_CHANGE, 32'd0, 32'd0};
          got       = 1'b1;
          seg_phase = PH_IL;
        end
        PH_IL: begin
          off_delta = accum;
          seg_phase = PH_SECOND;
        end
        PH_SECOND: begin
          if (off_delta == '0 && !no_record_yet) begin
            r         = '{KIND_DOC, accum, LINE_DOC_CHANGE, LINE_DOC_CHANGE, 32'd0, 32'd0};
            got       = 1'b1;
            seg_phase = PH_IL;
          end else begin
            span_lines = accum;
            seg_phase  = PH_COLS;
          end
        end
        PH_COLS: begin
          if (span_lines == '0 && accum == '0) begin
            r             = '{KIND_HIDDEN, off_delta, LINE_HIDDEN, LINE_HIDDEN, 32'd0, 32'd0};
            got           = 1'b1;
            no_record_yet = 1'b0;
            seg_phase     = PH_IL;
          end else begin
            // unsigned column span on a single line, signed otherwise
            span_cols = (span_lines == '0) ? {3'b000, accum} : sv;
            seg_phase = PH_SLINE;
          end
        end
        PH_SLINE: begin
          line_start = anchored ? prev_line + sv : {3'b000, accum};
          seg_phase  = PH_SCOL;
        end
        PH_SCOL: begin
          col = anchored ? prev_col + sv : {3'b000, accum};
          r   = '{KIND_POINT, off_delta, line_start, line_start + {3'b000, span_lines},
                  col, col + span_cols};
          got           = 1'b1;
          prev_line     = line_start;
          prev_col      = col;
          anchored      = 1'b1;
          no_record_yet = 1'b0;
          seg_phase     = PH_IL;
        end
        default: begin
          r       = '0;
          r.kind  = KIND_ERROR;
          got     = 1'b1;
          stopped = 1'b1;
        end
      endcase
    end

    if (fin && !stopped) begin
      stopped = 1'b1;
      // clean end only between records, after at least one record
      if (!(seg_phase == PH_IL && more_bytes == 2'd0 && !no_record_yet)) begin
        r      = '0;
        r.kind = KIND_ERROR;
        got    = 1'b1;
      end
    end
    if (got) want_q.insert(want_q.size(), r);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] seen);
    if (want !== seen) begin
      $display("%t mismatch on %s: expected %h, got %h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  task automatic check_record();
    record_t want;
    records_seen++;
    if (records.record_kind == KIND_POINT) points_seen++;
    if (records.record_kind == KIND_ERROR) errors_seen++;
    if (want_q.size() == 0) begin
      $display("%t unexpected record: kind %0d value %h lines %h..%h cols %h..%h",
               $time, records.record_kind, records.value_field, records.first_line,
               records.final_line, records.first_column, records.final_column);
      fail_count++;
      return;
    end
    want = want_q.pop_front();
    cmp_field("record_kind", {29'b0, want.kind}, {29'b0, records.record_kind});
    cmp_field("value_field", {3'b0, want.value}, {3'b0, records.value_field});
    cmp_field("first_line", want.line_a, records.first_line);
    cmp_field("final_line", want.line_b, records.final_line);
    cmp_field("first_column", want.col_a, records.first_column);
    cmp_field("final_column", want.col_b, records.final_column);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      want_q.delete();
    end else begin
      if (records.valid && records.ready) check_record();
      if (blob.valid && blob.ready)
        decode_byte(blob.data_byte, blob.blob_start, blob.blob_end, blob.single_document);
    end
    pending <= want_q.size();
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the sequence-points blob decoder: a few hand-built blobs
// hitting the corner cases, then random blobs, mostly well formed, some cut
// short, restarted, corrupted with bad prefixes or trailed by junk, with
// random stalls on both channels. All checking happens in spbd_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // one request on the byte channel
  typedef struct {
    logic [7:0] b;
    logic       start;
    logic       fin;
    logic       single;
    logic       noise;
  } blob_beat_t;

  logic clk;
  logic rst;

  spbd_in_if  blob_ch ();
  spbd_out_if rec_ch ();

  sequence_point_blob_decoder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .blob    (blob_ch),
    .records (rec_ch)
  );

  int fail_count;
  int pending;
  int records_seen;
  int points_seen;
  int errors_seen;

  spbd_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .blob         (blob_ch),
    .records      (rec_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .records_seen (records_seen),
    .points_seen  (points_seen),
    .errors_seen  (errors_seen)
  );

  blob_beat_t stream_q[$];
  int         bytes_sent;
  int         blobs_sent;
  int         cycle_count;
  bit         hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: the run must never get this far
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%t timeout after %0d cycles, %0d records still expected",
             $time, cycle_count, pending);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // record sink: random stalls, one quiet window with ready held high, and one
  // long hold-off so the output fills and the byte channel backs up
  // ---------------------------------------------------------------------------
  initial begin
    hold_done = 1'b0;
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bytes_sent >= 500 && !hold_done) begin
        rec_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (cycle_count >= 1500 && cycle_count < 2300)
        rec_ch.ready <= 1'b1;
      else
        rec_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // ---------------------------------------------------------------------------
  // blob building
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b);
    blob_beat_t e;
    e.b      = b;
    e.start  = 1'b0;
    e.fin    = 1'b0;
    e.single = 1'($urandom_range(0, 1));  // only sampled on the signature's last byte
    e.noise  = 1'b0;
    stream_q.insert(stream_q.size(), e);
  endtask

  // compressed integer in the given width class: 0 = 7, 1 = 14, 2 = 29 bits
  task automatic put_int_cls(input logic [28:0] v, input int cls);
    case (cls)
      0: add_byte({1'b0, v[6:0]});
      1: begin
        add_byte({2'b10, v[13:8]});
        add_byte(v[7:0]);
      end
      default: begin
        add_byte({3'b110, v[28:24]});
        add_byte(v[23:16]);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
      end
    endcase
  endtask

  // smallest width that fits, sometimes a wider one; the width also decides
  // where the sign of a rotated value is extended from
  task automatic put_int(input logic [28:0] v);
    int cls;
    cls = (v < 29'd128) ? 0 : (v < 29'd16384) ? 1 : 2;
    if (cls < 2 && $urandom_range(0, 99) < 15) cls = $urandom_range(cls + 1, 2);
    put_int_cls(v, cls);
  endtask

  // biased toward zero, small values and width extremes
  function automatic logic [28:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 20) begin
      case ($urandom_range(0, 3))
        0: return 29'h7F;
        1: return 29'h3FFF;
        2: return 29'h1FFF_FFFF;
        default: return 29'h1;
      endcase
    end
    if (sel < 55) return 29'($urandom_range(0, 127));
    if (sel < 80) return 29'($urandom_range(0, 16383));
    return 29'($urandom());
  endfunction

  task automatic seal_blob(input int first, input int sig_last, input bit single);
    stream_q[first].start                  = 1'b1;
    stream_q[stream_q.size() - 1].fin      = 1'b1;
    stream_q[sig_last].single              = single;
  endtask

  task automatic queue_record(input bit first_rec);
    logic [28:0] il;
    logic [28:0] ls;
    logic [28:0] cs;
    int          sel;
    sel = $urandom_range(0, 9);
    il  = pick_value();
    // a zero offset delta after the first record means document change
    if (!first_rec && il == '0) il = 29'd1;
    if (!first_rec && sel < 2) begin
      put_int('0);
      put_int(pick_value());
    end else if (sel < 4) begin
      put_int(il);
      put_int('0);
      put_int('0);
    end else begin
      ls = ($urandom_range(0, 3) == 0) ? '0 : pick_value();
      cs = pick_value();
      if (ls == '0 && cs == '0) cs = 29'd1;
      put_int(il);
      put_int(ls);
      put_int(cs);
      put_int(pick_value());
      put_int(pick_value());
    end
  endtask

  task automatic queue_random_blob();
    int first;
    int sig_last;
    int n_rec;
    int flaw;
    int cut;
    bit single;
    first  = stream_q.size();
    single = 1'($urandom_range(0, 1));
    n_rec  = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 8);
    flaw   = $urandom_range(0, 99);
    put_int(pick_value());
    sig_last = stream_q.size() - 1;
    if (!single) put_int(pick_value());
    for (int i = 0; i < n_rec; i++) queue_record(i == 0);
    seal_blob(first, sig_last, single);
    if (flaw < 10) begin
      // blob cut short at a random byte
      cut = $urandom_range(first, stream_q.size() - 1);
      while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
      stream_q[cut].fin = 1'b1;
    end else if (flaw < 18) begin
      // bad integer prefix somewhere in the blob
      cut = $urandom_range(first, stream_q.size() - 1);
      stream_q[cut].b = {3'b111, 5'($urandom())};
    end else if (flaw < 24) begin
      // no end mark: the next blob_start drops this one
      stream_q[stream_q.size() - 1].fin = 1'b0;
    end else if (flaw < 30) begin
      // junk after the end, must be ignored
      repeat ($urandom_range(1, 3)) begin
        add_byte(8'($urandom()));
        stream_q[stream_q.size() - 1].fin   = 1'($urandom_range(0, 1));
        stream_q[stream_q.size() - 1].noise = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: random gaps except in one calm stretch
  // ---------------------------------------------------------------------------
  task automatic send_stream();
    blob_beat_t e;
    bit         calm;
    while (stream_q.size() != 0) begin
      e    = stream_q.pop_front();
      calm = (bytes_sent >= 200 && bytes_sent < 400);
      if (!calm) begin
        while ($urandom_range(0, 99) < 20) begin
          blob_ch.valid <= 1'b0;
          @(posedge clk);
        end
      end
      blob_ch.valid           <= 1'b1;
      blob_ch.data_byte       <= e.b;
      blob_ch.blob_start      <= e.start;
      blob_ch.blob_end        <= e.fin;
      blob_ch.single_document <= e.single;
      @(posedge clk);
      while (!blob_ch.ready) @(posedge clk);
      if (!e.noise) bytes_sent++;
    end
  endtask

  // hold the byte channel idle until every predicted record has come out
  task automatic drain_records();
    blob_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    bytes_sent = 0;
    blobs_sent = 0;
    rst                     <= 1'b1;
    blob_ch.valid           <= 1'b0;
    blob_ch.data_byte       <= '0;
    blob_ch.blob_start      <= 1'b0;
    blob_ch.blob_end        <= 1'b0;
    blob_ch.single_document <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // known document: two points, the first absolute with an unsigned column
    // span on one line, the second with negative line and column deltas
    put_int_cls('0, 0);
    put_int_cls(29'd1, 0);
    put_int_cls('0, 0);
    put_int_cls(29'h3FFF, 1);
    put_int_cls(29'h3FFF, 1);
    put_int_cls('0, 0);
    put_int_cls(29'd1, 0);
    put_int_cls(29'd1, 0);
    put_int_cls(29'h7F, 0);
    put_int_cls(29'h7F, 0);
    put_int_cls(29'd1, 0);
    seal_blob(0, 0, 1'b1);
    send_stream();

    // initial document, largest signature, hidden first record with a zero
    // offset delta, then a document change
    put_int_cls(29'h1FFF_FFFF, 2);
    put_int_cls('0, 0);
    put_int_cls('0, 0);
    put_int_cls('0, 0);
    put_int_cls('0, 0);
    put_int_cls('0, 0);
    put_int_cls(29'd5, 0);
    seal_blob(0, 3, 1'b0);
    send_stream();

    // one-byte blob: header only, ends before any record
    add_byte(8'h05);
    seal_blob(0, 0, 1'b1);
    send_stream();

    // bad prefix on the first byte of a blob
    add_byte(8'hFF);
    seal_blob(0, 0, 1'b1);
    send_stream();
    drain_records();

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      queue_random_blob();
      send_stream();
      blobs_sent++;
      if (blobs_sent == 15) drain_records();
    end

    // wait for the tail, then idle for DRAIN_CYCLES to catch stray records
    drain_records();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d blob bytes in %0d random blobs plus directed ones", bytes_sent,
             blobs_sent);
    $display("checked %0d records: %0d sequence points, %0d errors", records_seen,
             points_seen, errors_seen);
    if (pending != 0) $display("%t %0d expected records never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spbd_pkg.sv
rtl/spbd_in_if.sv
rtl/spbd_out_if.sv
rtl/spbd_int_asm.sv
rtl/sequence_point_blob_decoder_top.sv
test/spbd_checker.sv
test/tb_top.sv
